[src/csim_pkg.sv]
// Shared constants and types for the cosine similarity unit.
`default_nettype none
package csim_pkg;
    localparam int LANES   = 4;
    localparam int MAX_DIM = 1024;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int DOT_W   = 42;
    localparam int NRM_W   = 41;
    localparam int PRD_W   = 2 * NRM_W;
    localparam int WIDE_W  = 116;

    typedef struct packed {
        logic signed [31:0] ab;
        logic        [31:0] aa;
        logic        [31:0] bb;
    } lane_prod_t;

    typedef struct packed {
        logic                    valid;
        logic                    too_long;
        logic signed [DOT_W-1:0] dot;
        logic        [NRM_W-1:0] na;
        logic        [NRM_W-1:0] nb;
    } launch_t;
endpackage
`default_nettype wire

[src/cosine_similarity_unit.sv]
// Top level: four multiplier lanes, merging accumulator and final unit.
// Throughput: one item per cycle for items not marked last.
// A last item stalls the input until its result transaction completes.
// Result: valid after the last item, once the 41-step serial multiplier and the
// 16-bit search (sum, square, diff, compare per bit) finish; zero norm skips both.
// Reset: rst_n asynchronous, active low, clears accumulators, counts and control.
`default_nettype none
module cosine_similarity_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] a_lane0,
    input  wire logic signed [15:0] a_lane1,
    input  wire logic signed [15:0] a_lane2,
    input  wire logic signed [15:0] a_lane3,
    input  wire logic signed [15:0] b_lane0,
    input  wire logic signed [15:0] b_lane1,
    input  wire logic signed [15:0] b_lane2,
    input  wire logic signed [15:0] b_lane3,
    input  wire logic [2:0]         lanes_valid,
    input  wire logic               last_group,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      similarity,
    output logic                    zero_norm,
    output logic                    too_long
);
    import csim_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg,   ovf_next;
    logic             busy_reg,  busy_next;
    logic             vld_reg,   vld_next;
    logic             last_reg,  last_next;
    logic             tl_reg,    tl_next;

    logic             in_acc;
    logic             out_acc;
    logic [CNT_W-1:0] n_req;
    logic [CNT_W-1:0] room;
    logic [CNT_W-1:0] used;
    logic             ovf_now;
    logic [LANES-1:0] lane_en;
    logic signed [15:0] a_in [LANES];
    logic signed [15:0] b_in [LANES];
    lane_prod_t       prods [LANES];
    launch_t          launch;

    assign a_in[0] = a_lane0;
    assign a_in[1] = a_lane1;
    assign a_in[2] = a_lane2;
    assign a_in[3] = a_lane3;
    assign b_in[0] = b_lane0;
    assign b_in[1] = b_lane1;
    assign b_in[2] = b_lane2;
    assign b_in[3] = b_lane3;

    assign in_stall = busy_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    always_comb
    begin
        // clamp the lane count, then cap it by what still fits up to MAX_DIM
        n_req   = (lanes_valid > 3'(LANES)) ? CNT_W'(LANES) : CNT_W'(lanes_valid);
        room    = CNT_W'(MAX_DIM) - count_reg;
        used    = (n_req < room) ? n_req : room;
        ovf_now = n_req > room;
        for (int i = 0; i < LANES; i++)
        begin
            lane_en[i] = in_acc && (CNT_W'(i) < used);
        end

        count_next = count_reg;
        ovf_next   = ovf_reg;
        busy_next  = busy_reg;
        last_next  = last_reg;
        tl_next    = tl_reg;
        vld_next   = in_acc;
        if (in_acc)
        begin
            last_next = last_group;
            tl_next   = ovf_reg || ovf_now;
            if (last_group)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                busy_next  = 1'b1;
            end
            else
            begin
                count_next = count_reg + used;
                ovf_next   = ovf_reg || ovf_now;
            end
        end
        if (out_acc)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            vld_reg   <= 1'b0;
            last_reg  <= 1'b0;
            tl_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            busy_reg  <= busy_next;
            vld_reg   <= vld_next;
            last_reg  <= last_next;
            tl_reg    <= tl_next;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        csim_lane u_lane (
            .clk  (clk),
            .en   (lane_en[g]),
            .a    (a_in[g]),
            .b    (b_in[g]),
            .prod (prods[g])
        );
    end

    csim_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld    (vld_reg),
        .last   (last_reg),
        .ovf    (tl_reg),
        .prods  (prods),
        .launch (launch)
    );

    csim_final u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .launch     (launch),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .similarity (similarity),
        .zero_norm  (zero_norm),
        .too_long   (too_long)
    );
endmodule
`default_nettype wire

[src/csim_lane.sv]
// One multiplier lane: registered a*b, a*a and b*b of one element pair.
`default_nettype none
module csim_lane (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [15:0] a,
    input  wire logic signed [15:0] b,
    output csim_pkg::lane_prod_t    prod
);
    import csim_pkg::*;

    lane_prod_t prod_reg;
    lane_prod_t prod_next;

    always_comb
    begin
        prod_next.ab = a * b;
        prod_next.aa = 32'(a * a);
        prod_next.bb = 32'(b * b);
        // drop lanes outside the count
        if (!en)
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

[src/csim_merge.sv]
// Merging stage: sums the lane products into the dot and norm accumulators.
`default_nettype none
module csim_merge (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 vld,
    input  wire logic                 last,
    input  wire logic                 ovf,
    input  csim_pkg::lane_prod_t      prods [csim_pkg::LANES],
    output csim_pkg::launch_t         launch
);
    import csim_pkg::*;

    logic signed [DOT_W-1:0] dot_reg,  dot_next;
    logic        [NRM_W-1:0] na_reg,   na_next;
    logic        [NRM_W-1:0] nb_reg,   nb_next;
    logic                    go_reg,   go_next;
    logic                    tl_reg,   tl_next;
    logic signed [DOT_W-1:0] sum_ab;
    logic        [NRM_W-1:0] sum_aa;
    logic        [NRM_W-1:0] sum_bb;

    always_comb
    begin
        sum_ab = '0;
        sum_aa = '0;
        sum_bb = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_ab = sum_ab + DOT_W'(prods[i].ab);
            sum_aa = sum_aa + NRM_W'(prods[i].aa);
            sum_bb = sum_bb + NRM_W'(prods[i].bb);
        end
        dot_next = dot_reg;
        na_next  = na_reg;
        nb_next  = nb_reg;
        go_next  = 1'b0;
        tl_next  = tl_reg;
        if (go_reg)
        begin
            // the final unit takes the sums this cycle; clear for the next pair
            dot_next = '0;
            na_next  = '0;
            nb_next  = '0;
        end
        else if (vld)
        begin
            dot_next = dot_reg + sum_ab;
            na_next  = na_reg + sum_aa;
            nb_next  = nb_reg + sum_bb;
            go_next  = last;
            tl_next  = ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            go_reg  <= 1'b0;
            tl_reg  <= 1'b0;
        end
        else
        begin
            dot_reg <= dot_next;
            na_reg  <= na_next;
            nb_reg  <= nb_next;
            go_reg  <= go_next;
            tl_reg  <= tl_next;
        end
    end

    assign launch.valid    = go_reg;
    assign launch.too_long = tl_reg;
    assign launch.dot      = dot_reg;
    assign launch.na       = na_reg;
    assign launch.nb       = nb_reg;
endmodule
`default_nettype wire

[src/csim_final.sv]
// Final unit: serial multiplies, then a bit-by-bit search for dot/sqrt(na*nb).
`default_nettype none
module csim_final (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  csim_pkg::launch_t launch,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic signed [15:0] similarity,
    output logic              zero_norm,
    output logic              too_long
);
    import csim_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SRCH = 4'b0100,
        ST_DONE = 4'b1000
    } fin_state_t;

    localparam logic [1:0] SUB_SUM  = 2'd0;
    localparam logic [1:0] SUB_SQ   = 2'd1;
    localparam logic [1:0] SUB_DIFF = 2'd2;
    localparam logic [1:0] SUB_CMP  = 2'd3;

    fin_state_t              state_reg, state_next;
    logic [5:0]              cnt_reg,   cnt_next;
    logic [1:0]              sub_reg,   sub_next;
    logic [3:0]              bit_reg,   bit_next;
    logic [15:0]             m_reg,     m_next;
    logic                    neg_reg,   neg_next;
    logic                    zn_reg,    zn_next;
    logic                    tl_reg,    tl_next;
    logic signed [15:0]      sim_reg,   sim_next;
    logic [PRD_W-1:0]        ma_reg,    ma_next;
    logic [NRM_W-1:0]        mb_reg,    mb_next;
    logic [PRD_W-1:0]        sa_reg,    sa_next;
    logic [NRM_W-1:0]        sb_reg,    sb_next;
    logic [PRD_W-1:0]        p_reg,     p_next;
    logic [PRD_W-1:0]        r_reg,     r_next;
    logic [WIDE_W-1:0]       q1_reg,    q1_next;
    logic [WIDE_W-1:0]       q2_reg,    q2_next;
    logic [WIDE_W-1:0]       t1_reg,    t1_next;
    logic [WIDE_W-1:0]       t2_reg,    t2_next;
    logic [WIDE_W-1:0]       d_reg,     d_next;

    logic [DOT_W-1:0]        dot_mag;
    logic [WIDE_W-1:0]       lhs;
    logic [WIDE_W-1:0]       rhs;
    logic [4:0]              sh1;
    logic [4:0]              sh2;
    logic [15:0]             m_try;
    logic [16:0]             m_neg;

    always_comb
    begin
        dot_mag = launch.dot[DOT_W-1] ? DOT_W'(-launch.dot) : DOT_W'(launch.dot);
        lhs     = (d_reg << 2) + WIDE_W'(p_reg);
        rhs     = WIDE_W'(r_reg) << 32;
        sh1     = {1'b0, bit_reg} + 5'd1;
        sh2     = {bit_reg, 1'b0};
        m_try   = m_reg | (16'd1 << bit_reg);
        m_neg   = '0;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        bit_next   = bit_reg;
        m_next     = m_reg;
        neg_next   = neg_reg;
        zn_next    = zn_reg;
        tl_next    = tl_reg;
        sim_next   = sim_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        q1_next    = q1_reg;
        q2_next    = q2_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        d_next     = d_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (launch.valid)
                begin
                    zn_next  = (launch.na == '0) || (launch.nb == '0);
                    tl_next  = launch.too_long;
                    neg_next = launch.dot[DOT_W-1];
                    ma_next  = PRD_W'(launch.na);
                    mb_next  = launch.nb;
                    sa_next  = PRD_W'(dot_mag);
                    sb_next  = NRM_W'(dot_mag);
                    p_next   = '0;
                    r_next   = '0;
                    cnt_next = '0;
                    sim_next = '0;
                    state_next = zn_next ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                // shift-add: na*nb and dot*dot side by side
                if (mb_reg[0])
                begin
                    p_next = p_reg + ma_reg;
                end
                if (sb_reg[0])
                begin
                    r_next = r_reg + sa_reg;
                end
                ma_next  = ma_reg << 1;
                sa_next  = sa_reg << 1;
                mb_next  = mb_reg >> 1;
                sb_next  = sb_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NRM_W - 1))
                begin
                    state_next = ST_SRCH;
                    bit_next   = 4'd15;
                    sub_next   = SUB_SUM;
                    m_next     = '0;
                    q1_next    = '0;
                    q2_next    = '0;
                end
            end
            ST_SRCH:
            begin
                // trial m' = m + 2^j: keep q1 = m*P and q2 = m*m*P,
                // test (2m'-1)^2*P = 4*(m'^2*P - m'*P) + P against dot^2 << 32
                case (sub_reg)
                    SUB_SUM:
                    begin
                        t2_next  = q2_reg + (q1_reg << sh1);
                        t1_next  = q1_reg + (WIDE_W'(p_reg) << bit_reg);
                        sub_next = SUB_SQ;
                    end
                    SUB_SQ:
                    begin
                        t2_next  = t2_reg + (WIDE_W'(p_reg) << sh2);
                        sub_next = SUB_DIFF;
                    end
                    SUB_DIFF:
                    begin
                        d_next   = t2_reg - t1_reg;
                        sub_next = SUB_CMP;
                    end
                    SUB_CMP:
                    begin
                        if (lhs <= rhs)
                        begin
                            m_next  = m_try;
                            q1_next = t1_reg;
                            q2_next = t2_reg;
                        end
                        sub_next = SUB_SUM;
                        bit_next = bit_reg - 4'd1;
                        if (bit_reg == 4'd0)
                        begin
                            m_neg = -{1'b0, m_next};
                            if (neg_reg)
                            begin
                                sim_next = m_neg[15:0];
                            end
                            else
                            begin
                                sim_next = m_next[15] ? 16'sh7FFF : m_next;
                            end
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        sub_next = SUB_SUM;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        sub_reg <= sub_next;
        bit_reg <= bit_next;
        m_reg   <= m_next;
        neg_reg <= neg_next;
        zn_reg  <= zn_next;
        tl_reg  <= tl_next;
        sim_reg <= sim_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        p_reg   <= p_next;
        r_reg   <= r_next;
        q1_reg  <= q1_next;
        q2_reg  <= q2_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        d_reg   <= d_next;
    end

    assign out_valid  = (state_reg == ST_DONE);
    assign similarity = sim_reg;
    assign zero_norm  = zn_reg;
    assign too_long   = tl_reg;

    a_zero_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> similarity == 16'sd0)
        else $error("zero norm result is not zero");

    a_launch_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && launch.valid |=> (state_reg != ST_IDLE))
        else $error("launch ignored");

    a_positive_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_norm && !neg_reg |-> !similarity[15])
        else $error("positive dot gave negative similarity");

    a_magnitude_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_norm |-> m_reg <= 16'd32768)
        else $error("magnitude above one");
endmodule
`default_nettype wire
